// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the RTL file ckps_seg.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Check that cond implies prop in the same cycle.
`define ASSERT_IMP(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("assertion failed");

// Check that cond implies prop in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed");

`endif

// ----- hdl/ckps_pkg.sv -----
package ckps_pkg;

	localparam int MAX_HEADER_BYTES_DEF = 4096;

	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	typedef enum logic [1:0] {
		KIND_NO_EQ    = 2'd0,
		KIND_REJECT   = 2'd1,
		KIND_ACCEPT   = 2'd2,
		KIND_TOO_LONG = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [11:0] name_offset;
		logic [12:0] name_length;
		logic [11:0] value_offset;
		logic [12:0] value_length;
		logic        final_segment;
	} res_t;

	function automatic logic tok_char(input logic [7:0] c);
		logic ok;
		ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
		     (c >= 8'h61 && c <= 8'h7A);
		case (c)
			8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
			8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: ok = 1'b1;
			default: ;
		endcase
		return ok;
	endfunction

	function automatic logic octet_ok(input logic [7:0] c);
		return c == 8'h21 || (c >= 8'h23 && c <= 8'h2B) ||
		       (c >= 8'h2D && c <= 8'h3A) || (c >= 8'h3C && c <= 8'h5B) ||
		       (c >= 8'h5D && c <= 8'h7E);
	endfunction

endpackage

// ----- hdl/ckps_seg.sv -----
`include "assert_macros.svh"

module ckps_seg import ckps_pkg::*; #(
	parameter int MAX_HEADER_BYTES = MAX_HEADER_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       res_valid,
	output res_t       res
);

	localparam int PW = $clog2(MAX_HEADER_BYTES);
	localparam int CW = $clog2(MAX_HEADER_BYTES + 1);
	localparam logic [CW-1:0] MaxPos = CW'(MAX_HEADER_BYTES);

	typedef struct packed {
		logic          after_sep;
		logic          nm_seen;
		logic          nm_bad;
		logic [PW-1:0] nm_first;
		logic [PW-1:0] nm_last;
		logic          vl_seen;
		logic          vl_fq;
		logic          vl_lq;
		logic          vl_lbad;
		logic          vl_rej;
		logic [PW-1:0] vl_first;
		logic [PW-1:0] vl_last;
	} seg_t;

	seg_t          seg_q, seg_nxt, seg_src, seg_d;
	logic [CW-1:0] pos_q, pos_d;
	logic          tl_q, tl_d;
	logic [PW-1:0] p;
	logic          blank;
	res_t          seg_res;

	assign p     = pos_q[PW-1:0];
	assign blank = (data_byte == CH_SP) || (data_byte == CH_TAB);

	// fold the current byte into the open segment
	always_comb begin
		seg_nxt = seg_q;
		if (!seg_q.after_sep) begin
			if (data_byte == CH_EQ) begin
				seg_nxt.after_sep = 1'b1;
			end else if (!blank) begin
				if (!seg_q.nm_seen) begin
					seg_nxt.nm_seen  = 1'b1;
					seg_nxt.nm_first = p;
				end else if (p != seg_q.nm_last + PW'(1)) begin
					seg_nxt.nm_bad = 1'b1;
				end
				seg_nxt.nm_last = p;
				if (!tok_char(data_byte)) seg_nxt.nm_bad = 1'b1;
			end
		end else if (!blank) begin
			if (!seg_q.vl_seen) begin
				seg_nxt.vl_seen  = 1'b1;
				seg_nxt.vl_fq    = (data_byte == CH_QUOTE);
				seg_nxt.vl_rej   = (data_byte != CH_QUOTE) && !octet_ok(data_byte);
				seg_nxt.vl_first = p;
			end else begin
				// an inner quote or bad octet only counts once another byte follows
				if (seg_q.vl_last != seg_q.vl_first && (seg_q.vl_lq || seg_q.vl_lbad))
					seg_nxt.vl_rej = 1'b1;
				if (p != seg_q.vl_last + PW'(1)) seg_nxt.vl_rej = 1'b1;
			end
			seg_nxt.vl_last = p;
			seg_nxt.vl_lq   = (data_byte == CH_QUOTE);
			seg_nxt.vl_lbad = (data_byte != CH_QUOTE) && !octet_ok(data_byte);
		end
	end

	// judge the segment that closes: ';' closes the state before this byte
	always_comb begin
		logic        ok;
		logic [31:0] nm_len, v_diff, v_off, v_len;
		seg_src = (data_byte == CH_SEMI) ? seg_q : seg_nxt;
		nm_len  = 32'(seg_src.nm_last) - 32'(seg_src.nm_first) + 32'd1;
		v_diff  = 32'(seg_src.vl_last) - 32'(seg_src.vl_first);
		v_off   = 32'd0;
		v_len   = 32'd0;
		ok      = seg_src.nm_seen && !seg_src.nm_bad;
		if (seg_src.vl_seen) begin
			if (seg_src.vl_fq || seg_src.vl_lq) begin
				if (seg_src.vl_last == seg_src.vl_first || !seg_src.vl_fq ||
				    !seg_src.vl_lq || seg_src.vl_rej)
					ok = 1'b0;
				v_off = 32'(seg_src.vl_first) + 32'd1;
				v_len = v_diff - 32'd1;
			end else begin
				if (seg_src.vl_rej || seg_src.vl_lbad) ok = 1'b0;
				v_off = 32'(seg_src.vl_first);
				v_len = v_diff + 32'd1;
			end
		end
		seg_res               = '0;
		seg_res.final_segment = last_byte;
		if (!seg_src.after_sep) begin
			seg_res.kind = KIND_NO_EQ;
		end else if (ok) begin
			seg_res.kind         = KIND_ACCEPT;
			seg_res.name_offset  = 12'(32'(seg_src.nm_first));
			seg_res.name_length  = nm_len[12:0];
			seg_res.value_offset = v_off[11:0];
			seg_res.value_length = v_len[12:0];
		end else begin
			seg_res.kind = KIND_REJECT;
		end
	end

	always_comb begin
		res_valid = 1'b0;
		res       = seg_res;
		seg_d     = seg_q;
		pos_d     = pos_q;
		tl_d      = tl_q;
		if (tl_q || pos_q >= MaxPos) begin
			// overlong header: drop everything until the last byte
			tl_d = 1'b1;
			res  = '0;
			if (last_byte) begin
				res_valid         = 1'b1;
				res.kind          = KIND_TOO_LONG;
				res.final_segment = 1'b1;
			end
		end else begin
			pos_d = pos_q + CW'(1);
			if (data_byte == CH_SEMI) begin
				res_valid = 1'b1;
				seg_d     = '0;
			end else begin
				res_valid = last_byte;
				seg_d     = seg_nxt;
			end
		end
		if (last_byte) begin
			seg_d = '0;
			pos_d = '0;
			tl_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= '0;
			pos_q <= '0;
			tl_q  <= 1'b0;
		end else if (step) begin
			seg_q <= seg_d;
			pos_q <= pos_d;
			tl_q  <= tl_d;
		end
	end

	`ASSERT_IMP(a_long_is_final, clk, arst_n, step && res_valid && res.kind == KIND_TOO_LONG, res.final_segment)
	`ASSERT_NEXT(a_last_clears, clk, arst_n, step && last_byte, pos_q == '0 && !tl_q && seg_q == '0)
	`ASSERT_IMP(a_reject_no_span, clk, arst_n, step && res_valid && res.kind != KIND_ACCEPT, res.name_length == '0 && res.value_length == '0 && res.value_offset == '0)
	`ASSERT_IMP(a_last_gives_result, clk, arst_n, step && last_byte, res_valid && res.final_segment)

endmodule

// ----- hdl/ckps_out.sv -----
module ckps_out import ckps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_in,
	input  logic ready,
	output logic free,
	output logic valid_q,
	output res_t res_q
);

	// slot is free when empty or being drained this cycle
	assign free = !valid_q || ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

// ----- hdl/cookie_header_pair_splitter.sv -----
// Cookie header splitter.
// Input channel (in_valid/in_ready): one header byte per word in data_byte,
// with last_byte high on the final byte of the header.
// Output channel (out_valid/out_ready): one word per segment end, at each ';'
// and at the last byte, giving kind, the trimmed name and value spans as
// offsets and lengths, and final_segment on the word that closes the header.
// Bytes that close no segment give no output word.
// A byte accepted into the input register is judged there; its word is loaded
// into the output register once the output slot is free, and shown from then on.
// Throughput: one byte per cycle while the output is not stalled, set by the
// segment state register that every byte updates.
// When the receiver stalls, a held output word stops the input register; the
// input stays ready as long as its register can move on or is empty.
// Reset clears the byte position, the segment state and both valid flags;
// the block starts at the first byte of a new header.
module cookie_header_pair_splitter import ckps_pkg::*; #(
	parameter int MAX_HEADER_BYTES = MAX_HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [11:0] name_offset,
	output logic [12:0] name_length,
	output logic [11:0] value_offset,
	output logic [12:0] value_length,
	output logic        final_segment
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       adv;
	logic       out_free;
	logic       res_valid;
	res_t       res, res_q;

	assign adv      = valid_s1 && out_free;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	ckps_seg #(
		.MAX_HEADER_BYTES(MAX_HEADER_BYTES)
	) u_seg (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv),
		.data_byte(data_s1),
		.last_byte(last_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	ckps_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv && res_valid),
		.res_in (res),
		.ready  (out_ready),
		.free   (out_free),
		.valid_q(out_valid),
		.res_q  (res_q)
	);

	assign kind          = res_q.kind;
	assign name_offset   = res_q.name_offset;
	assign name_length   = res_q.name_length;
	assign value_offset  = res_q.value_offset;
	assign value_length  = res_q.value_length;
	assign final_segment = res_q.final_segment;

endmodule

// ----- tb/tb_cookie_header_pair_splitter.sv -----
`timescale 1ns / 100ps

module tb_cookie_header_pair_splitter import ckps_pkg::*;;

	localparam int MAXB = MAX_HEADER_BYTES_DEF;
	localparam int RANDOM_WORDS = 1500;
	localparam int NUM_OPENING = 25;

	// segment flag bits
	localparam int NM_SEEN = 0;
	localparam int NM_BAD = 1;
	localparam int VL_SEEN = 0;
	localparam int VL_OPEN_Q = 1;
	localparam int VL_CLOSE_Q = 2;
	localparam int VL_TAIL_BAD = 3;
	localparam int VL_BAD = 4;

	localparam res_t NO_RES = '0;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
		logic       typed;
		res_t       want;
	} word_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [11:0] name_offset;
	logic [12:0] name_length;
	logic [11:0] value_offset;
	logic [12:0] value_length;
	logic        final_segment;

	cookie_header_pair_splitter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.name_offset(name_offset),
		.name_length(name_length),
		.value_offset(value_offset),
		.value_length(value_length),
		.final_segment(final_segment)
	);

	// parser state of the predictor
	logic [12:0] parse_pos = '0;
	logic        eq_seen = 1'b0;
	logic [11:0] name_lo = '0;
	logic [11:0] name_hi = '0;
	logic [2:0]  name_st = '0;
	logic [11:0] val_lo = '0;
	logic [11:0] val_hi = '0;
	logic [4:0]  val_st = '0;
	logic        overflowed = 1'b0;

	res_t        segment_results_due [$];
	logic [7:0]  hdr [$];
	word_t       cur_word;
	bit          steady = 1'b0;
	int          fault_count = 0;
	int          bytes_taken = 0;
	int          headers_taken = 0;
	int          kinds_seen [4];

	// Directed words; a result is typed in only on rows that close a segment.
	word_t opening [NUM_OPENING] = '{
		{8'h3B, 1'b1, 1'b1, KIND_NO_EQ, 12'd0, 13'd0, 12'd0, 13'd0, 1'b1},
		{8'h61, 1'b0, 1'b0, NO_RES},
		{8'h3D, 1'b0, 1'b0, NO_RES},
		{8'h3B, 1'b0, 1'b1, KIND_ACCEPT, 12'd0, 13'd1, 12'd0, 13'd0, 1'b0},
		{8'h3B, 1'b0, 1'b1, KIND_NO_EQ, 12'd0, 13'd0, 12'd0, 13'd0, 1'b0},
		{8'h62, 1'b0, 1'b0, NO_RES},
		{8'h3D, 1'b0, 1'b0, NO_RES},
		{8'h22, 1'b0, 1'b0, NO_RES},
		{8'h3B, 1'b0, 1'b1, KIND_REJECT, 12'd0, 13'd0, 12'd0, 13'd0, 1'b0},
		{8'h78, 1'b0, 1'b0, NO_RES},
		{8'h20, 1'b0, 1'b0, NO_RES},
		{8'h79, 1'b0, 1'b0, NO_RES},
		{8'h3D, 1'b0, 1'b0, NO_RES},
		{8'h31, 1'b1, 1'b1, KIND_REJECT, 12'd0, 13'd0, 12'd0, 13'd0, 1'b1},
		{8'hFF, 1'b0, 1'b0, NO_RES},
		{8'h3D, 1'b0, 1'b0, NO_RES},
		{8'h00, 1'b1, 1'b1, KIND_REJECT, 12'd0, 13'd0, 12'd0, 13'd0, 1'b1},
		{8'h09, 1'b0, 1'b0, NO_RES},
		{8'h6B, 1'b0, 1'b0, NO_RES},
		{8'h3D, 1'b0, 1'b0, NO_RES},
		{8'h76, 1'b0, 1'b0, NO_RES},
		{8'h22, 1'b1, 1'b1, KIND_REJECT, 12'd0, 13'd0, 12'd0, 13'd0, 1'b1},
		{8'h21, 1'b0, 1'b0, NO_RES},
		{8'h3D, 1'b0, 1'b0, NO_RES},
		{8'h7E, 1'b1, 1'b1, KIND_ACCEPT, 12'd0, 13'd1, 12'd2, 13'd1, 1'b1}
	};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("cookie_header_pair_splitter: mismatch");
		$finish;
	end

	// visible ASCII except the separators and the double quote
	function automatic bit is_token(input logic [7:0] c);
		if (c < 8'h21 || c > 8'h7E)
			return 1'b0;
		case (c)
			8'h22, 8'h28, 8'h29, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
			8'h3F, 8'h40, 8'h5B, 8'h5C, 8'h5D, 8'h7B, 8'h7D: return 1'b0;
			default: return 1'b1;
		endcase
	endfunction

	// visible ASCII except quote, comma, semicolon and backslash
	function automatic bit is_octet(input logic [7:0] c);
		return c >= 8'h21 && c <= 8'h7E && c != 8'h22 && c != 8'h2C &&
			c != 8'h3B && c != 8'h5C;
	endfunction

	function automatic res_t close_segment(input logic fin);
		res_t        r;
		bit          ok;
		logic [12:0] span;
		logic [11:0] vo;
		logic [12:0] vl;
		r = NO_RES;
		r.final_segment = fin;
		vo = '0;
		vl = '0;
		if (eq_seen) begin
			ok = name_st[NM_SEEN] && !name_st[NM_BAD];
			if (val_st[VL_SEEN]) begin
				span = {1'b0, val_hi} - {1'b0, val_lo} + 13'd1;
				if (val_st[VL_OPEN_Q] || val_st[VL_CLOSE_Q]) begin
					// quoted: both quotes needed, then strip them
					if (span < 13'd2 || !val_st[VL_OPEN_Q] || !val_st[VL_CLOSE_Q] ||
						val_st[VL_BAD])
						ok = 1'b0;
					vo = val_lo + 12'd1;
					vl = span - 13'd2;
				end else begin
					if (val_st[VL_BAD] || val_st[VL_TAIL_BAD])
						ok = 1'b0;
					vo = val_lo;
					vl = span;
				end
			end
			if (ok) begin
				r.kind = KIND_ACCEPT;
				r.name_offset = name_lo;
				r.name_length = {1'b0, name_hi} - {1'b0, name_lo} + 13'd1;
				r.value_offset = vo;
				r.value_length = vl;
			end else begin
				r.kind = KIND_REJECT;
			end
		end
		return r;
	endfunction

	task automatic clear_segment();
		eq_seen = 1'b0;
		name_lo = '0;
		name_hi = '0;
		name_st = '0;
		val_lo = '0;
		val_hi = '0;
		val_st = '0;
	endtask

	task automatic reset_parser();
		parse_pos = '0;
		overflowed = 1'b0;
		clear_segment();
	endtask

	task automatic split_cookie_byte(input logic [7:0] c, input logic fin,
			output bit emits, output res_t word);
		logic blank_c;
		emits = 1'b0;
		word = NO_RES;
		blank_c = (c == CH_SP) || (c == CH_TAB);
		if (overflowed || parse_pos >= MAXB) begin
			// past the size limit: swallow bytes, report once on the last one
			overflowed = 1'b1;
			if (fin) begin
				emits = 1'b1;
				word.kind = KIND_TOO_LONG;
				word.final_segment = 1'b1;
				reset_parser();
			end
		end else begin
			if (c == CH_SEMI) begin
				emits = 1'b1;
				word = close_segment(fin);
				clear_segment();
			end else begin
				if (!eq_seen) begin
					if (c == CH_EQ) begin
						eq_seen = 1'b1;
					end else if (!blank_c) begin
						if (!name_st[NM_SEEN]) begin
							name_st[NM_SEEN] = 1'b1;
							name_lo = parse_pos[11:0];
						end else if (parse_pos != {1'b0, name_hi} + 13'd1) begin
							name_st[NM_BAD] = 1'b1;
						end
						name_hi = parse_pos[11:0];
						if (!is_token(c))
							name_st[NM_BAD] = 1'b1;
					end
				end else if (!blank_c) begin
					if (!val_st[VL_SEEN]) begin
						val_st = '0;
						val_st[VL_SEEN] = 1'b1;
						val_lo = parse_pos[11:0];
						if (c == CH_QUOTE)
							val_st[VL_OPEN_Q] = 1'b1;
						else if (!is_octet(c))
							val_st[VL_BAD] = 1'b1;
					end else begin
						// a quote or bad byte is only fine as the final one
						if (val_hi != val_lo && (val_st[VL_CLOSE_Q] || val_st[VL_TAIL_BAD]))
							val_st[VL_BAD] = 1'b1;
						if (parse_pos != {1'b0, val_hi} + 13'd1)
							val_st[VL_BAD] = 1'b1;
					end
					val_hi = parse_pos[11:0];
					val_st[VL_CLOSE_Q] = 1'b0;
					val_st[VL_TAIL_BAD] = 1'b0;
					if (c == CH_QUOTE)
						val_st[VL_CLOSE_Q] = 1'b1;
					else if (!is_octet(c))
						val_st[VL_TAIL_BAD] = 1'b1;
				end
				if (fin) begin
					emits = 1'b1;
					word = close_segment(1'b1);
				end
			end
			parse_pos = parse_pos + 13'd1;
			if (fin)
				reset_parser();
		end
	endtask

	task automatic check_field(input string label, input int unsigned want,
			input int unsigned seen);
		if (want != seen) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, label, want, seen);
			fault_count++;
		end
	endtask

	always @(posedge clk) begin
		out_ready <= steady || $urandom_range(0, 99) >= 27;
	end

	always @(posedge clk) begin
		bit   emits;
		res_t word;
		res_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				bytes_taken++;
				if (cur_word.fin)
					headers_taken++;
				split_cookie_byte(cur_word.ch, cur_word.fin, emits, word);
				if (emits)
					segment_results_due.push_back(cur_word.typed ? cur_word.want : word);
			end
			if (out_valid && out_ready) begin
				kinds_seen[kind]++;
				if (segment_results_due.size() == 0) begin
					$display("%0t ns: word with nothing expected, kind %0d final %0d",
						$time, kind, final_segment);
					fault_count++;
				end else begin
					want = segment_results_due.pop_front();
					check_field("kind", want.kind, kind);
					check_field("name_offset", want.name_offset, name_offset);
					check_field("name_length", want.name_length, name_length);
					check_field("value_offset", want.value_offset, value_offset);
					check_field("value_length", want.value_length, value_length);
					check_field("final_segment", want.final_segment, final_segment);
				end
			end
		end
	end

	task automatic send_word(input word_t w);
		if (!steady)
			while ($urandom_range(0, 99) < 27) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		data_byte <= w.ch;
		last_byte <= w.fin;
		cur_word <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_header();
		word_t w;
		for (int i = 0; i < hdr.size(); i++) begin
			w = '0;
			w.ch = hdr[i];
			w.fin = (i == hdr.size() - 1);
			send_word(w);
		end
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (segment_results_due.size() != 0);
	endtask

	function automatic logic [7:0] pick_token();
		logic [7:0] c;
		do c = 8'($urandom_range(8'h21, 8'h7E)); while (!is_token(c));
		return c;
	endfunction

	function automatic logic [7:0] pick_octet();
		logic [7:0] c;
		do c = 8'($urandom_range(8'h21, 8'h7E)); while (!is_octet(c));
		return c;
	endfunction

	function automatic logic [7:0] pick_blank();
		return $urandom_range(0, 1) ? CH_SP : CH_TAB;
	endfunction

	// corrupt a byte now and then
	function automatic logic [7:0] noisy(input logic [7:0] c);
		return ($urandom_range(0, 99) < 4) ? 8'($urandom_range(0, 255)) : c;
	endfunction

	task automatic add_segment();
		bit quoted;
		if ($urandom_range(0, 99) < 72) begin
			repeat ($urandom_range(0, 3) / 2) hdr.push_back(pick_blank());
			repeat ($urandom_range(1, 6)) hdr.push_back(noisy(pick_token()));
			repeat ($urandom_range(0, 3) / 2) hdr.push_back(pick_blank());
			hdr.push_back(CH_EQ);
			repeat ($urandom_range(0, 3) / 2) hdr.push_back(pick_blank());
			quoted = $urandom_range(0, 99) < 25;
			if (quoted)
				hdr.push_back(CH_QUOTE);
			repeat ($urandom_range(0, 8)) hdr.push_back(noisy(pick_octet()));
			if (quoted && $urandom_range(0, 9) != 0)
				hdr.push_back(CH_QUOTE);
			repeat ($urandom_range(0, 3) / 2) hdr.push_back(pick_blank());
		end else begin
			// broken segment: separators, quotes and raw bytes in any order
			repeat ($urandom_range(0, 8)) begin
				case ($urandom_range(0, 5))
					0: hdr.push_back(CH_EQ);
					1: hdr.push_back(CH_QUOTE);
					2: hdr.push_back(pick_blank());
					3: hdr.push_back(pick_token());
					4: hdr.push_back(8'($urandom_range(0, 255)));
					default: hdr.push_back(pick_octet());
				endcase
			end
		end
	endtask

	// min_len of 0 gives a short header; otherwise fill and cut to min_len
	task automatic compose_header(input int min_len);
		int nseg;
		hdr.delete();
		nseg = $urandom_range(1, 4);
		for (int i = 0; i < nseg || hdr.size() < min_len; i++) begin
			if (i != 0) begin
				hdr.push_back(CH_SEMI);
				if ($urandom_range(0, 1))
					hdr.push_back(CH_SP);
			end
			add_segment();
		end
		if ($urandom_range(0, 9) == 0)
			hdr.push_back(CH_SEMI);
		if (hdr.size() == 0)
			hdr.push_back(CH_SEMI);
		if (min_len != 0)
			while (hdr.size() > min_len)
				void'(hdr.pop_back());
	endtask

	initial begin
		int random_words;
		int hdr_idx;
		int long_i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		out_ready = 1'b0;
		cur_word = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_OPENING; i++)
			send_word(opening[i]);

		random_words = 0;
		hdr_idx = 0;
		long_i = 0;
		while (random_words < RANDOM_WORDS) begin
			steady = (hdr_idx >= 20 && hdr_idx < 36);
			if (hdr_idx % 10 == 5 && long_i < 5) begin
				// five headers near the size limit: just under, at and past it
				if (long_i == 4) begin
					hdr.delete();
					hdr.push_back(8'h76);
					hdr.push_back(CH_EQ);
					while (hdr.size() < MAXB)
						hdr.push_back(pick_octet());
				end else begin
					compose_header(long_i == 0 ? MAXB : long_i == 1 ? MAXB + 1 :
						long_i == 2 ? MAXB - 1 : MAXB + 200);
				end
				long_i++;
			end else begin
				compose_header(0);
				random_words += hdr.size();
			end
			send_header();
			if (hdr_idx == 12)
				hold_until_drained();
			hdr_idx++;
		end
		steady = 1'b0;

		hold_until_drained();
		repeat (8) @(posedge clk);
		$display("%0d bytes in %0d headers, short ones plus headers at and past %0d bytes",
			bytes_taken, headers_taken, MAXB);
		$display("segments closed: %0d without '=', %0d rejected, %0d accepted, %0d too long",
			kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3]);
		if (fault_count == 0)
			$display("cookie_header_pair_splitter: match");
		else
			$display("cookie_header_pair_splitter: mismatch");
		$finish;
	end

endmodule
